// File: sv/etg_pkg.sv
// ----------------------------------------------------------------------------
// etg_pkg: shared definitions for the easing tween generator
// Field widths, register indexes, curve codes and the serial unit status word.
// ----------------------------------------------------------------------------
package etg_pkg;

  // defaults for the top level parameters
  localparam int FRACTION_BITS_DEF = 16;
  localparam int TIME_BITS_DEF     = 32;

  // fixed field widths
  localparam int DELTA_W    = 16;
  localparam int EASED_W    = 17;
  localparam int VALUE_W    = 32;
  localparam int DIFF_W     = VALUE_W + 1;
  localparam int CURVE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURVE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END      = 2'd3;

  // curve codes
  localparam logic [CURVE_W-1:0] CURVE_LINEAR = 2'd0;
  localparam logic [CURVE_W-1:0] CURVE_IN     = 2'd1;
  localparam logic [CURVE_W-1:0] CURVE_OUT    = 2'd2;
  localparam logic [CURVE_W-1:0] CURVE_INOUT  = 2'd3;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } etg_sts_t;

endpackage

// File: sv/easing_tween_generator.sv
// ----------------------------------------------------------------------------
// easing_tween_generator: quadratic easing tween, one result word per tick
// Elapsed-time counter, serial progress divider and shared serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one tick word: delta_time and
//   restart. Each accepted word yields exactly one result word on the
//   output channel (out_valid/out_stall): eased_progress, interpolated
//   and done_res.
//   Config writes (cfg_wr_en, cfg_index, cfg_data) go in while idle.
// Sequence (F = FRACTION_BITS):
//   The divider produces F+1 quotient bits, one per cycle; the shared
//   multiplier then runs once for the curve and once for the lerp. The
//   linear curve skips the curve multiply.
//   One word in flight: in_stall is high from accept until the result is
//   moved into the output register.
// Reset: config registers zero, elapsed time zero, no result pending.
// Output stall: a finished result waits in the output register; the next
// tick is still taken and computed, and only holds at its last step.
// ----------------------------------------------------------------------------
module easing_tween_generator
  import etg_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // config port
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  // tick input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [DELTA_W-1:0]          in_delta_time,
  input  logic                        in_restart,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [EASED_W-1:0]          out_eased_progress,
  output logic signed [VALUE_W-1:0]   out_interpolated,
  output logic                        out_done_res
);

  // progress width: Q0.F plus one bit for exactly one
  localparam int XW  = FRACTION_BITS + 1;
  localparam int SQW = 2 * FRACTION_BITS + 2;
  localparam int PW  = DIFF_W + 1 + XW;
  localparam logic [XW-1:0]  ONE_Q  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [XW-1:0]  HALF_Q = ONE_Q >> 1;
  localparam logic [SQW-1:0] ONE_SQ = SQW'(1) << (2 * FRACTION_BITS);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SHGO  = 3'd2;
  localparam logic [2:0] S_SHAPE = 3'd3;
  localparam logic [2:0] S_LRGO  = 3'd4;
  localparam logic [2:0] S_LERP  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // config registers
  logic [CURVE_W-1:0]        curve_r;
  logic [CFG_DATA_W-1:0]     duration_r;
  logic signed [VALUE_W-1:0] start_r;
  logic signed [VALUE_W-1:0] end_r;

  logic [2:0]                state_r;
  logic [2:0]                state_nxt;
  logic [TIME_BITS-1:0]      elapsed_r;
  logic [TIME_BITS-1:0]      elapsed_nxt;
  logic                      done_r;
  logic [XW-1:0]             prog_r;
  logic [XW-1:0]             eased_r;
  logic [VALUE_W-1:0]        res_r;

  logic                      out_valid_r;
  logic [EASED_W-1:0]        out_eased_r;
  logic signed [VALUE_W-1:0] out_interp_r;
  logic                      out_done_r;

  logic                      in_acc;
  logic                      out_load;
  logic [TIME_BITS-1:0]      dur_w;
  logic [TIME_BITS:0]        sum_w;
  logic signed [DIFF_W-1:0]  diff_w;
  logic [XW-1:0]             rem_q;
  logic [XW:0]               two_minus_x;
  logic                      low_half;
  logic [SQW-1:0]            sq_p;
  logic [XW-1:0]             shaped;

  logic [XW-1:0]             div_quot;
  etg_sts_t                  div_sts;
  logic                      mul_start;
  logic [XW-1:0]             mul_a;
  logic signed [DIFF_W-1:0]  mul_b;
  logic signed [PW-1:0]      mul_prod;
  etg_sts_t                  mul_sts;

  // ---------------- config port ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_r    <= CURVE_LINEAR;
      duration_r <= '0;
      start_r    <= '0;
      end_r      <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CURVE:    curve_r    <= cfg_data[CURVE_W-1:0];
        REG_DURATION: duration_r <= cfg_data;
        REG_START:    start_r    <= cfg_data[VALUE_W-1:0];
        REG_END:      end_r      <= cfg_data[VALUE_W-1:0];
        default:      ;
      endcase
    end
  end

  // ---------------- elapsed time ----------------
  // duration wraps or zero-extends to the counter width
  assign dur_w  = TIME_BITS'(duration_r);
  assign sum_w  = {1'b0, elapsed_r} + (TIME_BITS + 1)'(in_delta_time);
  assign in_acc = in_valid && !in_stall;

  // restart clears; else saturate at duration, which also pulls elapsed down after duration shrinks
  always_comb begin
    if (in_restart) begin
      elapsed_nxt = '0;
    end else if (sum_w > {1'b0, dur_w}) begin
      elapsed_nxt = dur_w;
    end else begin
      elapsed_nxt = sum_w[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (in_acc) begin
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      done_r <= (elapsed_nxt >= dur_w);
    end
  end

  // ---------------- progress divider ----------------
  etg_div #(
    .TB (TIME_BITS),
    .QW (XW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .num   (elapsed_nxt),
    .den   (dur_w),
    .quot  (div_quot),
    .sts   (div_sts)
  );

  // ---------------- shared multiplier ----------------
  assign diff_w      = {end_r[VALUE_W-1], end_r} - {start_r[VALUE_W-1], start_r};
  assign rem_q       = ONE_Q - prog_r;
  assign two_minus_x = {ONE_Q, 1'b0} - {1'b0, prog_r};
  assign low_half    = prog_r < HALF_Q;

  // curve pass: x*x, x*(2-x) or (1-x)^2; lerp pass: eased*(end-start)
  always_comb begin
    mul_a = prog_r;
    mul_b = DIFF_W'(prog_r);
    if (state_r == S_LRGO) begin
      mul_a = eased_r;
      mul_b = diff_w;
    end else begin
      case (curve_r)
        CURVE_OUT: begin
          mul_b = DIFF_W'(two_minus_x);
        end
        CURVE_INOUT: begin
          if (!low_half) begin
            mul_a = rem_q;
            mul_b = DIFF_W'(rem_q);
          end
        end
        default: ;
      endcase
    end
  end

  assign mul_start = ((state_r == S_SHGO) && (curve_r != CURVE_LINEAR)) ||
                     (state_r == S_LRGO);

  etg_mul #(
    .AW (XW),
    .BW (DIFF_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .sts   (mul_sts)
  );

  // curve product back to Q1.F, truncating
  assign sq_p = mul_prod[SQW-1:0];

  always_comb begin
    case (curve_r)
      CURVE_INOUT: begin
        if (low_half) begin
          shaped = XW'(sq_p >> (FRACTION_BITS - 1));
        end else begin
          shaped = XW'((ONE_SQ - {sq_p[SQW-2:0], 1'b0}) >> FRACTION_BITS);
        end
      end
      default: shaped = XW'(sq_p >> FRACTION_BITS);
    endcase
  end

  // ---------------- sequencer ----------------
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_DIV;
      S_DIV:   if (div_sts.done) state_nxt = S_SHGO;
      S_SHGO:  state_nxt = (curve_r == CURVE_LINEAR) ? S_LRGO : S_SHAPE;
      S_SHAPE: if (mul_sts.done) state_nxt = S_LRGO;
      S_LRGO:  state_nxt = S_LERP;
      S_LERP:  if (mul_sts.done) state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    if ((state_r == S_DIV) && div_sts.done) begin
      prog_r <= (dur_w == '0) ? ONE_Q : div_quot;
    end
    if ((state_r == S_SHGO) && (curve_r == CURVE_LINEAR)) begin
      eased_r <= prog_r;
    end else if ((state_r == S_SHAPE) && mul_sts.done) begin
      eased_r <= shaped;
    end
    // floor division by 2^F is the arithmetic shift; keep the low word
    if ((state_r == S_LERP) && mul_sts.done) begin
      res_r <= start_r + mul_prod[FRACTION_BITS+VALUE_W-1:FRACTION_BITS];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_eased_r  <= EASED_W'(eased_r);
      out_interp_r <= res_r;
      out_done_r   <= done_r;
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_eased_progress = out_eased_r;
  assign out_interpolated   = out_interp_r;
  assign out_done_res       = out_done_r;

  // ---------------- assertions ----------------
`ifndef SYNTHESIS
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_sts.busy && mul_sts.busy))
    else $error("divider and multiplier busy together");

  a_div_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> div_sts.busy)
    else $error("divider not started by accepted tick");

  a_done_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_eased_progress == EASED_W'(ONE_Q)))
    else $error("finished tween without full eased progress");
`endif

endmodule

// File: sv/etg_div.sv
// ----------------------------------------------------------------------------
// etg_div: serial restoring divider
// Computes floor(num * 2^(QW-1) / den) for num <= den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module etg_div
  import etg_pkg::*;
#(
  parameter int TB = TIME_BITS_DEF,
  parameter int QW = FRACTION_BITS_DEF + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [TB-1:0] num,
  input  logic [TB-1:0] den,
  output logic [QW-1:0] quot,
  output etg_sts_t      sts
);

  localparam int CW = $clog2(QW + 1);

  logic [TB-1:0] rem_r;
  logic [TB-1:0] den_r;
  logic [QW-1:0] quot_r;
  logic [CW-1:0] cnt_r;
  logic          first_r;
  logic          done_r;

  logic [TB:0] trial;
  logic [TB:0] trial_sub;
  logic        ge;

  // first step compares the numerator itself, later steps the doubled remainder
  always_comb begin
    trial     = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge        = trial >= {1'b0, den_r};
    trial_sub = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(QW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= num;
      den_r   <= den;
      first_r <= 1'b1;
    end else if (cnt_r != '0) begin
      rem_r   <= ge ? trial_sub[TB-1:0] : trial[TB-1:0];
      quot_r  <= {quot_r[QW-2:0], ge};
      first_r <= 1'b0;
    end
  end

  assign quot     = quot_r;
  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;

endmodule

// File: sv/etg_mul.sv
// ----------------------------------------------------------------------------
// etg_mul: serial shift-add multiplier
// Unsigned a times signed b, one bit of a per cycle, LSB first.
// ----------------------------------------------------------------------------
module etg_mul
  import etg_pkg::*;
#(
  parameter int AW = FRACTION_BITS_DEF + 1,
  parameter int BW = DIFF_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [AW-1:0]       a,
  input  logic signed [BW-1:0] b,
  output logic signed [BW+AW:0] prod,
  output etg_sts_t            sts
);

  localparam int CW = $clog2(AW + 1);

  logic signed [BW:0]   hi_r;
  logic [AW-1:0]        lo_r;
  logic signed [BW-1:0] b_r;
  logic [CW-1:0]        cnt_r;
  logic                 done_r;

  logic signed [BW:0] addend;
  logic signed [BW:0] sum;

  // partial sum stays within twice |b|, so BW+1 bits hold it
  always_comb begin
    addend = lo_r[0] ? {b_r[BW-1], b_r} : '0;
    sum    = hi_r + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(AW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // multiplier bits shift out of lo_r as product bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      hi_r <= '0;
      lo_r <= a;
      b_r  <= b;
    end else if (cnt_r != '0) begin
      hi_r <= {sum[BW], sum[BW:1]};
      lo_r <= {sum[0], lo_r[AW-1:1]};
    end
  end

  assign prod     = {hi_r, lo_r};
  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;

endmodule
